// ===== src/smpq_pkg.sv =====
`default_nettype none
package smpq_pkg;

	localparam int MAX_SEGMENTS = 256;
	localparam int MAX_LAYERS   = 16;

	localparam int SEG_AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int SEG_CW = $clog2(MAX_SEGMENTS + 1);

	localparam int COORD_W = 24;
	localparam int FLIP_W  = COORD_W + 2;
	localparam int DIFF_W  = COORD_W + 1;
	localparam int MUL_W   = DIFF_W + 1;
	localparam int PROD_W  = 2 * MUL_W;
	localparam int DEN_W   = 2 * COORD_W + 1;
	localparam int NUM_W   = 2 * DEN_W;
	localparam int DIV_STEPS = NUM_W - DEN_W;
	localparam int QW      = DEN_W + 1;
	localparam int ROOT_W  = QW / 2;
	localparam int SQ_LO_W = DEN_W / 2 + 1;
	localparam int DIST_W  = 24;
	localparam int M_W     = QW + 4;

	localparam int WIDTH_W = 16;
	localparam int KSQ_W   = 2 * WIDTH_W;
	localparam int LAYER_W = 4;

	localparam int TSIZE_W    = 23;
	localparam int SCOUNT_W   = 9;
	localparam int LCOUNT_W   = 5;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 23;

	localparam logic [DIST_W-1:0]  DIST_MAX    = '1;
	localparam logic [WIDTH_W-1:0] LINE_MIN_2X = WIDTH_W'(384);
	localparam logic [WIDTH_W-1:0] WALL_MIN_2X = WIDTH_W'(256);

	localparam logic [CFG_IDX_W-1:0] CFG_TABLE_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_TABLE_HEIGHT = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_SEG_COUNT    = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] CFG_LAYER_COUNT  = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] CFG_GROUND_LAYER = CFG_IDX_W'(4);

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		logic [TSIZE_W-1:0]  table_width;
		logic [TSIZE_W-1:0]  table_height;
		logic [SEG_CW-1:0]   seg_n;
		logic [LCOUNT_W-1:0] layer_count;
		logic [LAYER_W-1:0]  ground_layer;
	} cfg_t;

	typedef struct packed {
		coord_t              sx;
		coord_t              sy;
		coord_t              ex;
		coord_t              ey;
		logic [LAYER_W-1:0]  layer;
		logic                wall;
		logic [WIDTH_W-1:0]  width;
	} seg_rec_t;

	typedef struct packed {
		logic                is_query;
		logic [SEG_AW-1:0]   addr;
		seg_rec_t            rec;
		coord_t              px;
		coord_t              py;
		logic [LAYER_W-1:0]  sel;
	} qent_t;

endpackage
`default_nettype wire

// ===== src/segment_map_proximity_query_core.sv =====
`default_nettype none
// A segment write is queued on acceptance and written into the table when the idle back end
// pops it. A query walks the configured slots: a slot of another layer is dropped after its read,
// a slot whose nearest point is an endpoint takes the short path, and any other slot runs the
// 49-step divider; border edges skip the table read. Two 25-step root extractions close the query.
// Throughput: one request at a time in the back end; busy rises only while two requests wait.
// done is a one-cycle strobe; the receiver cannot stall. Reset restores config, empties queue.
module segment_map_proximity_query_core (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	output logic                        busy,
	input  wire logic                   req_type,
	input  wire logic [7:0]             entry_index,
	input  wire logic [3:0]             seg_layer,
	input  wire logic                   seg_is_wall,
	input  wire logic signed [23:0]     seg_start_x,
	input  wire logic signed [23:0]     seg_start_y,
	input  wire logic signed [23:0]     seg_end_x,
	input  wire logic signed [23:0]     seg_end_y,
	input  wire logic [15:0]            seg_width,
	input  wire logic signed [23:0]     point_x,
	input  wire logic signed [23:0]     point_y,
	input  wire logic [3:0]             query_layer,
	input  wire logic                   cfg_we,
	input  wire logic [smpq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [smpq_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                        done,
	output logic                        on_line,
	output logic                        on_wall,
	output logic [23:0]                 line_distance,
	output logic                        line_found,
	output logic [23:0]                 wall_distance,
	output logic                        wall_found
);
	import smpq_pkg::*;

	logic [TSIZE_W-1:0]  table_width_q, table_height_q;
	logic [SCOUNT_W-1:0] segment_count_q;
	logic [LCOUNT_W-1:0] layer_count_q;
	logic [LAYER_W-1:0]  ground_layer_q;
	cfg_t                cfg;
	logic                q_valid, pop;
	qent_t               q_ent;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_width_q   <= '0;
			table_height_q  <= '0;
			segment_count_q <= '0;
			layer_count_q   <= LCOUNT_W'(1);
			ground_layer_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TABLE_WIDTH:  table_width_q   <= cfg_data[TSIZE_W-1:0];
				CFG_TABLE_HEIGHT: table_height_q  <= cfg_data[TSIZE_W-1:0];
				CFG_SEG_COUNT:    segment_count_q <= cfg_data[SCOUNT_W-1:0];
				CFG_LAYER_COUNT:  layer_count_q   <= cfg_data[LCOUNT_W-1:0];
				CFG_GROUND_LAYER: ground_layer_q  <= cfg_data[LAYER_W-1:0];
				default: begin end
			endcase
		end
	end

	always_comb begin
		cfg.table_width  = table_width_q;
		cfg.table_height = table_height_q;
		// clamp the walk to the table depth
		cfg.seg_n        = (32'(segment_count_q) > MAX_SEGMENTS) ? SEG_CW'(MAX_SEGMENTS)
		                                                         : SEG_CW'(segment_count_q);
		cfg.layer_count  = layer_count_q;
		cfg.ground_layer = ground_layer_q;
	end

	smpq_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.req_type    (req_type),
		.entry_index (entry_index),
		.seg_layer   (seg_layer),
		.seg_is_wall (seg_is_wall),
		.seg_start_x (seg_start_x),
		.seg_start_y (seg_start_y),
		.seg_end_x   (seg_end_x),
		.seg_end_y   (seg_end_y),
		.seg_width   (seg_width),
		.point_x     (point_x),
		.point_y     (point_y),
		.query_layer (query_layer),
		.cfg         (cfg),
		.q_valid     (q_valid),
		.q_ent       (q_ent),
		.pop         (pop)
	);

	smpq_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_ent         (q_ent),
		.pop           (pop),
		.cfg           (cfg),
		.done          (done),
		.on_line       (on_line),
		.on_wall       (on_wall),
		.line_distance (line_distance),
		.line_found    (line_found),
		.wall_distance (wall_distance),
		.wall_found    (wall_found)
	);

endmodule
`default_nettype wire

// ===== src/smpq_front.sv =====
`default_nettype none
module smpq_front (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic                         req_type,
	input  wire logic [7:0]                   entry_index,
	input  wire logic [3:0]                   seg_layer,
	input  wire logic                         seg_is_wall,
	input  wire logic signed [23:0]           seg_start_x,
	input  wire logic signed [23:0]           seg_start_y,
	input  wire logic signed [23:0]           seg_end_x,
	input  wire logic signed [23:0]           seg_end_y,
	input  wire logic [15:0]                  seg_width,
	input  wire logic signed [23:0]           point_x,
	input  wire logic signed [23:0]           point_y,
	input  wire logic [3:0]                   query_layer,
	input  wire smpq_pkg::cfg_t               cfg,
	output logic                              q_valid,
	output smpq_pkg::qent_t                   q_ent,
	input  wire logic                         pop
);
	import smpq_pkg::*;

	function automatic coord_t flip_y(input logic [TSIZE_W-1:0] th, input coord_t y);
		logic signed [FLIP_W-1:0] fy;
		fy = $signed({{(FLIP_W-TSIZE_W){1'b0}}, th}) - FLIP_W'(y);
		if (fy[FLIP_W-1:COORD_W-1] == '0 || fy[FLIP_W-1:COORD_W-1] == '1) begin
			return fy[COORD_W-1:0];
		end
		return fy[FLIP_W-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
	endfunction

	qent_t             buf_q [2];
	logic              wr_ptr_q, rd_ptr_q;
	logic [1:0]        count_q;
	qent_t             ent;
	logic              accept, push, in_range, sel_ok;

	assign busy     = (count_q == 2'd2);
	assign accept   = start && !busy;
	assign in_range = (32'(entry_index) < MAX_SEGMENTS);
	assign push     = accept && (req_type || in_range);
	assign sel_ok   = (5'(query_layer) < cfg.layer_count) && (32'(query_layer) < MAX_LAYERS);

	always_comb begin
		ent.is_query  = req_type;
		ent.addr      = SEG_AW'(entry_index);
		ent.rec.sx    = seg_start_x;
		ent.rec.sy    = flip_y(cfg.table_height, seg_start_y);
		ent.rec.ex    = seg_end_x;
		ent.rec.ey    = flip_y(cfg.table_height, seg_end_y);
		ent.rec.layer = seg_layer;
		ent.rec.wall  = seg_is_wall;
		ent.rec.width = seg_width;
		ent.px        = point_x;
		ent.py        = point_y;
		ent.sel       = sel_ok ? query_layer : cfg.ground_layer;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= ent;
		end
	end

	assign q_valid = (count_q != 2'd0);
	assign q_ent   = buf_q[rd_ptr_q];

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != 2'd0)
		else $error("request popped from empty queue");

endmodule
`default_nettype wire

// ===== src/smpq_div.sv =====
`default_nettype none
module smpq_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [smpq_pkg::NUM_W-1:0]    num,
	input  wire logic [smpq_pkg::DEN_W-1:0]    den,
	output logic                               busy,
	output logic [smpq_pkg::DEN_W-1:0]         quo,
	output logic [smpq_pkg::DEN_W-1:0]         rem
);
	import smpq_pkg::*;

	localparam int CNT_W = $clog2(DIV_STEPS + 1);

	logic                 run_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [DEN_W-1:0]     rem_q, den_q;
	logic [DIV_STEPS-1:0] low_q;
	logic [DEN_W:0]       trial;
	logic                 ge;

	assign trial = {rem_q, low_q[DIV_STEPS-1]};
	assign ge    = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			cnt_q <= CNT_W'(DIV_STEPS);
		end else if (run_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				run_q <= 1'b0;
			end
		end
	end

	// one quotient bit per cycle, MSB first
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num[NUM_W-1:DIV_STEPS];
			low_q <= num[DIV_STEPS-1:0];
			den_q <= den;
		end else if (run_q) begin
			rem_q <= ge ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
			low_q <= {low_q[DIV_STEPS-2:0], ge};
		end
	end

	assign busy = run_q;
	assign quo  = DEN_W'(low_q);
	assign rem  = rem_q;

endmodule
`default_nettype wire

// ===== src/smpq_isqrt.sv =====
`default_nettype none
module smpq_isqrt (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [smpq_pkg::QW-1:0]       rad,
	output logic                               busy,
	output logic [smpq_pkg::ROOT_W-1:0]        root
);
	import smpq_pkg::*;

	localparam int REM_W = ROOT_W + 4;
	localparam int CNT_W = $clog2(ROOT_W + 1);

	logic              run_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [QW-1:0]     rad_q;
	logic [REM_W-1:0]  rem_q, rem_sh, trial;
	logic [ROOT_W-1:0] root_q;
	logic              ge;

	assign rem_sh = {rem_q[REM_W-3:0], rad_q[QW-1 -: 2]};
	assign trial  = REM_W'({root_q, 2'b01});
	assign ge     = (rem_sh >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			cnt_q <= CNT_W'(ROOT_W);
		end else if (run_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				run_q <= 1'b0;
			end
		end
	end

	// two radicand bits in, one root bit out per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (run_q) begin
			rad_q  <= {rad_q[QW-3:0], 2'b00};
			rem_q  <= ge ? (rem_sh - trial) : rem_sh;
			root_q <= {root_q[ROOT_W-2:0], ge};
		end
	end

	assign busy = run_q;
	assign root = root_q;

endmodule
`default_nettype wire

// ===== src/smpq_back.sv =====
`default_nettype none
module smpq_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          q_valid,
	input  wire smpq_pkg::qent_t               q_ent,
	output logic                               pop,
	input  wire smpq_pkg::cfg_t                cfg,
	output logic                               done,
	output logic                               on_line,
	output logic                               on_wall,
	output logic [23:0]                        line_distance,
	output logic                               line_found,
	output logic [23:0]                        wall_distance,
	output logic                               wall_found
);
	import smpq_pkg::*;

	typedef enum logic [24:0] {
		S_IDLE = 25'h0000001,
		S_CHK  = 25'h0000002,
		S_RD   = 25'h0000004,
		S_LD   = 25'h0000008,
		S_BRD  = 25'h0000010,
		S_SUB  = 25'h0000020,
		S_C1A  = 25'h0000040,
		S_C1B  = 25'h0000080,
		S_C2A  = 25'h0000100,
		S_C2B  = 25'h0000200,
		S_CLS  = 25'h0000400,
		S_EPA  = 25'h0000800,
		S_EPB  = 25'h0001000,
		S_CRA  = 25'h0002000,
		S_CRB  = 25'h0004000,
		S_SQA  = 25'h0008000,
		S_SQB  = 25'h0010000,
		S_SQC  = 25'h0020000,
		S_DIVS = 25'h0040000,
		S_DIVW = 25'h0080000,
		S_EVAL = 25'h0100000,
		S_RTLS = 25'h0200000,
		S_RTLW = 25'h0400000,
		S_RTWS = 25'h0800000,
		S_RTWW = 25'h1000000
	} state_t;

	state_t state_q, state_d;

	seg_rec_t mem [MAX_SEGMENTS];
	seg_rec_t rd_q;

	logic [SEG_CW-1:0]  i_q;
	logic [2:0]         e_q;
	logic               brd_q;
	logic               done_q, on_line_q, on_wall_q, line_found_q, wall_found_q;
	logic [QW-1:0]      lmin_q, wmin_q;
	logic [DIST_W-1:0]  line_d_q, wall_d_q;

	coord_t             px_q, py_q, sx_q, sy_q, ex_q, ey_q;
	logic [LAYER_W-1:0] sel_q;
	logic               wall_q, is_sel_q, is_gnd_q, ep_end_q;
	logic [WIDTH_W-1:0] k_q;
	logic [KSQ_W-1:0]   ksq_q;
	logic signed [DIFF_W-1:0] vx_q, vy_q, wx_q, wy_q, ux_q, uy_q;
	logic signed [PROD_W-1:0] c1_q, c2_q, cr_q;
	logic [NUM_W-1:0]   num_q;
	logic [QW-1:0]      q_q;
	logic [DEN_W-1:0]   r_q, den_q;

	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic signed [PROD_W-1:0] prod, cr_abs;
	logic [NUM_W-1:0]   pext;
	logic [SQ_LO_W-1:0] al;
	logic [DEN_W-SQ_LO_W-1:0] ah;
	logic               border_en, write_req, query_req, tag_sel, tag_gnd, endpoint;
	logic [WIDTH_W-1:0] kmin, kseg;
	logic signed [M_W-1:0] m;
	logic [DEN_W+1:0]   mden, r4;
	logic               in_reach;
	logic               div_busy, sq_busy;
	logic [DEN_W-1:0]   div_quo, div_rem;
	logic [ROOT_W-1:0]  sq_root;
	logic [DIST_W-1:0]  dist_sat;
	coord_t             tw, th;

	assign write_req = (state_q == S_IDLE) && q_valid && !q_ent.is_query;
	assign query_req = (state_q == S_IDLE) && q_valid && q_ent.is_query;
	assign pop       = (state_q == S_IDLE) && q_valid;
	assign border_en = (cfg.table_width != '0) && (cfg.table_height != '0);
	assign tw        = COORD_W'(cfg.table_width);
	assign th        = COORD_W'(cfg.table_height);

	assign tag_sel = (rd_q.layer == sel_q);
	assign tag_gnd = (rd_q.layer == cfg.ground_layer);
	assign kmin    = rd_q.wall ? WALL_MIN_2X : LINE_MIN_2X;
	assign kseg    = (rd_q.width > kmin) ? rd_q.width : kmin;

	assign cr_abs = cr_q[PROD_W-1] ? -cr_q : cr_q;
	assign al     = cr_abs[SQ_LO_W-1:0];
	assign ah     = cr_abs[DEN_W-1:SQ_LO_W];
	assign endpoint = c1_q[PROD_W-1] || (c1_q == '0) || (c2_q <= c1_q);

	// shared multiplier, operands picked by step
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_SUB: begin mul_a = MUL_W'(k_q);  mul_b = MUL_W'(k_q);  end
			S_C1A: begin mul_a = MUL_W'(vx_q); mul_b = MUL_W'(wx_q); end
			S_C1B: begin mul_a = MUL_W'(vy_q); mul_b = MUL_W'(wy_q); end
			S_C2A: begin mul_a = MUL_W'(vx_q); mul_b = MUL_W'(vx_q); end
			S_C2B: begin mul_a = MUL_W'(vy_q); mul_b = MUL_W'(vy_q); end
			S_EPA: begin
				mul_a = MUL_W'(ep_end_q ? ux_q : wx_q);
				mul_b = MUL_W'(ep_end_q ? ux_q : wx_q);
			end
			S_EPB: begin
				mul_a = MUL_W'(ep_end_q ? uy_q : wy_q);
				mul_b = MUL_W'(ep_end_q ? uy_q : wy_q);
			end
			S_CRA: begin mul_a = MUL_W'(vx_q); mul_b = MUL_W'(wy_q); end
			S_CRB: begin mul_a = MUL_W'(vy_q); mul_b = MUL_W'(wx_q); end
			S_SQA: begin mul_a = MUL_W'(al);   mul_b = MUL_W'(al);   end
			S_SQB: begin mul_a = MUL_W'(al);   mul_b = MUL_W'(ah);   end
			S_SQC: begin mul_a = MUL_W'(ah);   mul_b = MUL_W'(ah);   end
			default: begin end
		endcase
	end

	assign prod = mul_a * mul_b;
	assign pext = {{(NUM_W-PROD_W){1'b0}}, prod};

	// exact check of 4*num <= k^2*den using num = q*den + r
	assign m        = $signed({{(M_W-KSQ_W){1'b0}}, ksq_q}) - $signed({2'b00, q_q, 2'b00});
	assign mden     = (m[0] ? {2'b00, den_q} : '0) + (m[1] ? {1'b0, den_q, 1'b0} : '0);
	assign r4       = {r_q, 2'b00};
	assign in_reach = !m[M_W-1] && ((|m[M_W-2:2]) || (r4 <= mden));

	assign dist_sat = sq_root[ROOT_W-1] ? DIST_MAX : sq_root[DIST_W-1:0];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (query_req) state_d = S_CHK;
			S_CHK: begin
				if (!brd_q) begin
					if (i_q < cfg.seg_n) state_d = S_RD;
					else if (border_en) state_d = S_BRD;
					else state_d = S_RTLS;
				end else begin
					state_d = (e_q < 3'd4) ? S_BRD : S_RTLS;
				end
			end
			S_RD:   state_d = S_LD;
			S_LD:   state_d = (tag_sel || tag_gnd) ? S_SUB : S_CHK;
			S_BRD:  state_d = S_SUB;
			S_SUB:  state_d = S_C1A;
			S_C1A:  state_d = S_C1B;
			S_C1B:  state_d = S_C2A;
			S_C2A:  state_d = S_C2B;
			S_C2B:  state_d = S_CLS;
			S_CLS:  state_d = endpoint ? S_EPA : S_CRA;
			S_EPA:  state_d = S_EPB;
			S_EPB:  state_d = S_EVAL;
			S_CRA:  state_d = S_CRB;
			S_CRB:  state_d = S_SQA;
			S_SQA:  state_d = S_SQB;
			S_SQB:  state_d = S_SQC;
			S_SQC:  state_d = S_DIVS;
			S_DIVS: state_d = S_DIVW;
			S_DIVW: if (!div_busy) state_d = S_EVAL;
			S_EVAL: state_d = S_CHK;
			S_RTLS: state_d = S_RTLW;
			S_RTLW: if (!sq_busy) state_d = S_RTWS;
			S_RTWS: state_d = S_RTWW;
			S_RTWW: if (!sq_busy) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			i_q          <= '0;
			e_q          <= '0;
			brd_q        <= 1'b0;
			done_q       <= 1'b0;
			on_line_q    <= 1'b0;
			on_wall_q    <= 1'b0;
			line_found_q <= 1'b0;
			wall_found_q <= 1'b0;
			lmin_q       <= '1;
			wmin_q       <= '1;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == S_RTWW) && !sq_busy;
			if (query_req) begin
				i_q          <= '0;
				e_q          <= '0;
				brd_q        <= 1'b0;
				on_line_q    <= 1'b0;
				on_wall_q    <= 1'b0;
				line_found_q <= 1'b0;
				wall_found_q <= 1'b0;
				lmin_q       <= '1;
				wmin_q       <= '1;
			end
			if (state_q == S_CHK && !brd_q && !(i_q < cfg.seg_n) && border_en) begin
				brd_q <= 1'b1;
			end
			if (state_q == S_LD && !(tag_sel || tag_gnd)) begin
				i_q <= i_q + 1'b1;
			end
			if (state_q == S_EVAL) begin
				if (brd_q) e_q <= e_q + 1'b1;
				else i_q <= i_q + 1'b1;
				if (is_sel_q && in_reach) begin
					if (wall_q) on_wall_q <= 1'b1;
					else on_line_q <= 1'b1;
				end
				if (is_gnd_q) begin
					if (wall_q) begin
						wall_found_q <= 1'b1;
						if (q_q < wmin_q) wmin_q <= q_q;
					end else begin
						line_found_q <= 1'b1;
						if (q_q < lmin_q) lmin_q <= q_q;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (write_req) begin
			mem[q_ent.addr] <= q_ent.rec;
		end
		rd_q <= mem[i_q[SEG_AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (query_req) begin
			px_q  <= q_ent.px;
			py_q  <= q_ent.py;
			sel_q <= q_ent.sel;
		end
		case (state_q)
			S_LD: begin
				sx_q     <= rd_q.sx;
				sy_q     <= rd_q.sy;
				ex_q     <= rd_q.ex;
				ey_q     <= rd_q.ey;
				wall_q   <= rd_q.wall;
				k_q      <= kseg;
				is_sel_q <= tag_sel;
				is_gnd_q <= tag_gnd;
			end
			S_BRD: begin
				// border edges run counterclockwise from the origin
				sx_q     <= (e_q == 3'd1 || e_q == 3'd2) ? tw : '0;
				sy_q     <= (e_q == 3'd2 || e_q == 3'd3) ? th : '0;
				ex_q     <= (e_q == 3'd0 || e_q == 3'd1) ? tw : '0;
				ey_q     <= (e_q == 3'd1 || e_q == 3'd2) ? th : '0;
				wall_q   <= 1'b1;
				k_q      <= WALL_MIN_2X;
				is_sel_q <= 1'b1;
				is_gnd_q <= 1'b1;
			end
			S_SUB: begin
				vx_q  <= DIFF_W'(ex_q) - DIFF_W'(sx_q);
				vy_q  <= DIFF_W'(ey_q) - DIFF_W'(sy_q);
				wx_q  <= DIFF_W'(px_q) - DIFF_W'(sx_q);
				wy_q  <= DIFF_W'(py_q) - DIFF_W'(sy_q);
				ux_q  <= DIFF_W'(px_q) - DIFF_W'(ex_q);
				uy_q  <= DIFF_W'(py_q) - DIFF_W'(ey_q);
				ksq_q <= prod[KSQ_W-1:0];
			end
			S_C1A: c1_q <= prod;
			S_C1B: c1_q <= c1_q + prod;
			S_C2A: c2_q <= prod;
			S_C2B: c2_q <= c2_q + prod;
			S_CLS: ep_end_q <= !(c1_q[PROD_W-1] || (c1_q == '0));
			S_EPA: num_q <= pext;
			S_EPB: begin
				q_q   <= QW'(num_q + pext);
				r_q   <= '0;
				den_q <= DEN_W'(1);
			end
			S_CRA: cr_q <= prod;
			S_CRB: cr_q <= cr_q - prod;
			S_SQA: num_q <= pext;
			S_SQB: num_q <= num_q + (pext << (SQ_LO_W + 1));
			S_SQC: begin
				num_q <= num_q + (pext << (2 * SQ_LO_W));
				den_q <= c2_q[DEN_W-1:0];
			end
			S_DIVW: begin
				if (!div_busy) begin
					q_q <= QW'(div_quo);
					r_q <= div_rem;
				end
			end
			S_RTLW: if (!sq_busy) line_d_q <= dist_sat;
			S_RTWW: if (!sq_busy) wall_d_q <= dist_sat;
			default: begin end
		endcase
	end

	smpq_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == S_DIVS),
		.num    (num_q),
		.den    (den_q),
		.busy   (div_busy),
		.quo    (div_quo),
		.rem    (div_rem)
	);

	smpq_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == S_RTLS || state_q == S_RTWS),
		.rad    ((state_q == S_RTLS) ? lmin_q : wmin_q),
		.busy   (sq_busy),
		.root   (sq_root)
	);

	assign done          = done_q;
	assign on_line       = on_line_q;
	assign on_wall       = on_wall_q;
	assign line_distance = line_d_q;
	assign line_found    = line_found_q;
	assign wall_distance = wall_d_q;
	assign wall_found    = wall_found_q;

	a_div_started: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIVS |=> div_busy)
		else $error("divider did not start");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe held");

	a_line_found: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EVAL && is_gnd_q && !wall_q |=> line_found_q)
		else $error("ground line not recorded");

endmodule
`default_nettype wire

// ===== sim/segment_map_proximity_query_core_test.sv =====
`timescale 1ns / 1ps
module segment_map_proximity_query_core_test;
	import smpq_pkg::*;

	typedef struct {
		bit          on_line;
		bit          on_wall;
		bit [23:0]   line_dist;
		bit          line_hit;
		bit [23:0]   wall_dist;
		bit          wall_hit;
	} proximity_t;

	localparam int STALL_LIMIT = 100000;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic                  req_type;
	logic [7:0]            entry_index;
	logic [3:0]            seg_layer;
	logic                  seg_is_wall;
	logic signed [23:0]    seg_start_x;
	logic signed [23:0]    seg_start_y;
	logic signed [23:0]    seg_end_x;
	logic signed [23:0]    seg_end_y;
	logic [15:0]           seg_width;
	logic signed [23:0]    point_x;
	logic signed [23:0]    point_y;
	logic [3:0]            query_layer;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  done;
	logic                  on_line;
	logic                  on_wall;
	logic [23:0]           line_distance;
	logic                  line_found;
	logic [23:0]           wall_distance;
	logic                  wall_found;

	segment_map_proximity_query_core uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req_type(req_type), .entry_index(entry_index), .seg_layer(seg_layer),
		.seg_is_wall(seg_is_wall), .seg_start_x(seg_start_x), .seg_start_y(seg_start_y),
		.seg_end_x(seg_end_x), .seg_end_y(seg_end_y), .seg_width(seg_width),
		.point_x(point_x), .point_y(point_y), .query_layer(query_layer),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data), .done(done),
		.on_line(on_line), .on_wall(on_wall), .line_distance(line_distance),
		.line_found(line_found), .wall_distance(wall_distance), .wall_found(wall_found)
	);

	// mirror of the segment table, y already flipped
	longint      tab_sx [MAX_SEGMENTS];
	longint      tab_sy [MAX_SEGMENTS];
	longint      tab_ex [MAX_SEGMENTS];
	longint      tab_ey [MAX_SEGMENTS];
	bit [3:0]    tab_layer [MAX_SEGMENTS];
	bit          tab_wall [MAX_SEGMENTS];
	bit [15:0]   tab_width [MAX_SEGMENTS];

	bit [22:0]   m_width, m_height;
	bit [8:0]    m_seg_n;
	bit [4:0]    m_layer_n;
	bit [3:0]    m_ground;

	proximity_t  pending_answers [$];
	int          fail_count;
	int          write_count, query_count, answer_count;
	int          stall_cycles;
	bit          gaps_on;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic longint sat24(longint v);
		if (v > 8388607) return 8388607;
		if (v < -8388608) return -8388608;
		return v;
	endfunction

	function automatic longint mag(longint v);
		return (v < 0) ? -v : v;
	endfunction

	// squared distance from point to segment as num / den
	function automatic void seg_metric(longint px, longint py, longint sx, longint sy,
			longint ex, longint ey, output logic [127:0] num, output logic [127:0] den);
		longint vx, vy, wx, wy, c1, c2, dx, dy, a;
		vx = ex - sx; vy = ey - sy; wx = px - sx; wy = py - sy;
		c1 = vx * wx + vy * wy;
		c2 = vx * vx + vy * vy;
		if (c1 <= 0 || c2 <= c1) begin
			dx = (c1 <= 0) ? wx : px - ex;
			dy = (c1 <= 0) ? wy : py - ey;
			num = 128'(dx * dx) + 128'(dy * dy);
			den = 1;
		end else begin
			a = mag(vx * wy - vy * wx);
			num = 128'(a) * 128'(a);
			den = 128'(c2);
		end
	endfunction

	function automatic bit near_enough(logic [127:0] num, logic [127:0] den, longint k);
		return (num << 2) <= 128'(k * k) * den;
	endfunction

	function automatic bit [23:0] floor_distance(logic [127:0] num, logic [127:0] den);
		longint lo, hi, mid;
		lo = 0; hi = 16777215;
		while (lo < hi) begin
			mid = (lo + hi + 1) >>> 1;
			if (128'(mid * mid) * den <= num) lo = mid; else hi = mid - 1;
		end
		return lo[23:0];
	endfunction

	function automatic proximity_t predict_query(longint px, longint py, bit [3:0] ql);
		proximity_t r;
		bit [3:0] sel;
		int n;
		longint k, bw, bh;
		logic [127:0] num, den;
		bit [23:0] d;
		longint cx [5];
		longint cy [5];
		r = '{0, 0, 24'hFFFFFF, 0, 24'hFFFFFF, 0};
		sel = (ql < m_layer_n && ql < MAX_LAYERS) ? ql : m_ground;
		n = (m_seg_n < MAX_SEGMENTS) ? int'(m_seg_n) : MAX_SEGMENTS;
		for (int i = 0; i < n; i++) begin
			if (tab_layer[i] != sel && tab_layer[i] != m_ground) continue;
			k = tab_wall[i] ? 256 : 384;
			if (tab_width[i] > k) k = longint'(tab_width[i]);
			seg_metric(px, py, tab_sx[i], tab_sy[i], tab_ex[i], tab_ey[i], num, den);
			if (tab_layer[i] == sel && near_enough(num, den, k)) begin
				if (tab_wall[i]) r.on_wall = 1; else r.on_line = 1;
			end
			if (tab_layer[i] == m_ground) begin
				d = floor_distance(num, den);
				if (tab_wall[i]) begin
					r.wall_hit = 1;
					if (d < r.wall_dist) r.wall_dist = d;
				end else begin
					r.line_hit = 1;
					if (d < r.line_dist) r.line_dist = d;
				end
			end
		end
		if (m_width > 0 && m_height > 0) begin
			bw = longint'(m_width); bh = longint'(m_height);
			cx = '{0, bw, bw, 0, 0};
			cy = '{0, 0, bh, bh, 0};
			for (int e = 0; e < 4; e++) begin
				seg_metric(px, py, cx[e], cy[e], cx[e+1], cy[e+1], num, den);
				if (near_enough(num, den, 256)) r.on_wall = 1;
				d = floor_distance(num, den);
				r.wall_hit = 1;
				if (d < r.wall_dist) r.wall_dist = d;
			end
		end
		return r;
	endfunction

	// hold the request until busy is low, then account for it
	task automatic send_request(bit is_query, bit [7:0] idx, bit [3:0] layer, bit wall,
			coord_t sx, coord_t sy, coord_t ex, coord_t ey, bit [15:0] w,
			coord_t px, coord_t py, bit [3:0] ql);
		start <= 1'b1;
		req_type <= is_query;
		entry_index <= idx;
		seg_layer <= layer;
		seg_is_wall <= wall;
		seg_start_x <= sx;
		seg_start_y <= sy;
		seg_end_x <= ex;
		seg_end_y <= ey;
		seg_width <= w;
		point_x <= px;
		point_y <= py;
		query_layer <= ql;
		forever begin
			@(negedge clk);
			if (!busy) break;
			@(posedge clk);
		end
		@(posedge clk);
		if (is_query) begin
			pending_answers = {pending_answers, predict_query(px, py, ql)};
			query_count++;
		end else begin
			tab_sx[idx] = longint'(sx);
			tab_sy[idx] = sat24(longint'(m_height) - longint'(sy));
			tab_ex[idx] = longint'(ex);
			tab_ey[idx] = sat24(longint'(m_height) - longint'(ey));
			tab_layer[idx] = layer;
			tab_wall[idx] = wall;
			tab_width[idx] = w;
			write_count++;
		end
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic write_segment(bit [7:0] idx, bit [3:0] layer, bit wall,
			coord_t sx, coord_t sy, coord_t ex, coord_t ey, bit [15:0] w);
		send_request(0, idx, layer, wall, sx, sy, ex, ey, w,
			coord_t'($urandom), coord_t'($urandom), 4'($urandom));
	endtask

	task automatic run_query(coord_t px, coord_t py, bit [3:0] ql);
		send_request(1, 8'($urandom), 4'($urandom), 1'($urandom), coord_t'($urandom),
			coord_t'($urandom), coord_t'($urandom), coord_t'($urandom), 16'($urandom),
			px, py, ql);
	endtask

	// drain every answer, then let trailing writes settle
	task automatic wait_idle();
		start <= 1'b0;
		while (pending_answers.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(value);
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_TABLE_WIDTH:  m_width = value[22:0];
			CFG_TABLE_HEIGHT: m_height = value[22:0];
			CFG_SEG_COUNT:    m_seg_n = value[8:0];
			CFG_LAYER_COUNT:  m_layer_n = value[4:0];
			CFG_GROUND_LAYER: m_ground = value[3:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_config(int unsigned tw, int unsigned th, int unsigned sn,
			int unsigned ln, int unsigned gl);
		wait_idle();
		write_reg(CFG_TABLE_WIDTH, tw);
		write_reg(CFG_TABLE_HEIGHT, th);
		write_reg(CFG_SEG_COUNT, sn);
		write_reg(CFG_LAYER_COUNT, ln);
		write_reg(CFG_GROUND_LAYER, gl);
	endtask

	function automatic coord_t box_coord();
		return coord_t'(int'($urandom_range(0, 45000)) - 5000);
	endfunction

	function automatic int unsigned pick_size();
		case ($urandom_range(0, 3))
			0: return 0;
			1: return 8388607;
			default: return $urandom_range(2000, 40000);
		endcase
	endfunction

	// every slot gets a value so no query can walk an unwritten one
	task automatic test_fill_table();
		set_config(0, $urandom_range(0, 40000), 0, 1, 0);
		for (int i = 0; i < MAX_SEGMENTS; i++)
			write_segment(8'(i), 4'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
				box_coord(), box_coord(), box_coord(), box_coord(),
				16'($urandom_range(0, 1500)));
	endtask

	task automatic test_directed();
		set_config(0, 8388607, 4, 16, 0);
		// flipped y saturates at the positive limit
		write_segment(0, 0, 0, -8388608, -8388608, 8388607, 8388607, 16'h0000);
		write_segment(1, 0, 1, 100, 100, 100, 100, 16'hFFFF);
		write_segment(2, 15, 0, 0, 0, 2560, 0, 1000);
		write_segment(3, 15, 1, 0, -256, 0, -256, 0);
		run_query(-8388608, -8388608, 0);
		run_query(8388607, 8388607, 0);
		run_query(1280, 8388607, 15);
		run_query(0, 8388607, 15);
		set_config(0, 8388607, 4, 4, 0);
		run_query(1280, 8388607, 15);
		set_config(0, 8388607, 4, 1, 7);
		run_query(100, 8388507, 3);
		set_config(8388607, 8388607, 4, 16, 15);
		run_query(0, 0, 15);
		run_query(-100, 50, 0);
		set_config(1000, 1000, 0, 16, 0);
		run_query(500, 500, 0);
		run_query(1100, 1128, 2);
		set_config(0, 0, 0, 1, 0);
		run_query(0, 0, 0);
		// count above the table size walks every slot
		set_config(0, 0, 511, 16, 0);
		run_query(box_coord(), box_coord(), 1);
	endtask

	task automatic test_random(int phases, int per_phase);
		int n, s;
		coord_t px, py;
		for (int p = 0; p < phases; p++) begin
			if (p == phases - 2) gaps_on = 0;
			n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
			set_config(pick_size(), pick_size(), n,
				($urandom_range(0, 2) == 0) ? 16 : $urandom_range(1, 16),
				$urandom_range(0, 3) == 0 ? $urandom_range(0, 15) : $urandom_range(0, 3));
			for (int i = 0; i < per_phase; i++) begin
				if ($urandom_range(0, 9) < 3) begin
					if ($urandom_range(0, 9) == 0)
						write_segment(8'($urandom), 4'($urandom), 1'($urandom),
							coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
							coord_t'($urandom), 16'($urandom));
					else
						write_segment(8'($urandom_range(0, 255)), 4'($urandom_range(0, 3)),
							1'($urandom), box_coord(), box_coord(), box_coord(), box_coord(),
							16'($urandom_range(0, 1500)));
				end else begin
					s = $urandom_range(0, (n > 0) ? n - 1 : 0);
					case ($urandom_range(0, 9))
						0, 1: begin px = coord_t'($urandom); py = coord_t'($urandom); end
						2, 3: begin px = box_coord(); py = box_coord(); end
						default: begin
							px = coord_t'(sat24(tab_sx[s] + int'($urandom_range(0, 600)) - 300));
							py = coord_t'(sat24(tab_sy[s] + int'($urandom_range(0, 600)) - 300));
						end
					endcase
					run_query(px, py,
						4'(($urandom_range(0, 1)) ? $urandom_range(0, 3) : $urandom));
				end
			end
		end
	endtask

	always @(negedge clk) begin
		proximity_t exp_r;
		if (done) begin
			answer_count++;
			if (pending_answers.size() == 0) begin
				$error("unexpected result with no query outstanding");
				fail_count++;
			end else begin
				exp_r = pending_answers.pop_front();
				if (on_line !== exp_r.on_line) begin
					$error("on_line exp %0d got %0d", exp_r.on_line, on_line);
					fail_count++;
				end
				if (on_wall !== exp_r.on_wall) begin
					$error("on_wall exp %0d got %0d", exp_r.on_wall, on_wall);
					fail_count++;
				end
				if (line_distance !== exp_r.line_dist) begin
					$error("line_distance exp %0d got %0d", exp_r.line_dist, line_distance);
					fail_count++;
				end
				if (line_found !== exp_r.line_hit) begin
					$error("line_found exp %0d got %0d", exp_r.line_hit, line_found);
					fail_count++;
				end
				if (wall_distance !== exp_r.wall_dist) begin
					$error("wall_distance exp %0d got %0d", exp_r.wall_dist, wall_distance);
					fail_count++;
				end
				if (wall_found !== exp_r.wall_hit) begin
					$error("wall_found exp %0d got %0d", exp_r.wall_hit, wall_found);
					fail_count++;
				end
			end
		end
	end

	always @(negedge clk) begin
		if (done || (start && !busy)) stall_cycles = 0;
		else stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		req_type = 1'b0;
		entry_index = '0;
		seg_layer = '0;
		seg_is_wall = 1'b0;
		seg_start_x = '0;
		seg_start_y = '0;
		seg_end_x = '0;
		seg_end_y = '0;
		seg_width = '0;
		point_x = '0;
		point_y = '0;
		query_layer = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		m_width = 0; m_height = 0; m_seg_n = 0; m_layer_n = 1; m_ground = 0;
		gaps_on = 1;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_fill_table();
		test_directed();
		test_random(16, 100);
		wait_idle();
		repeat (200) @(posedge clk);
		$display("covered %0d segment writes and %0d queries, %0d answers checked",
			write_count, query_count, answer_count);
		$display("sweep included border edges on and off, layer fallback and full walks");
		if (fail_count == 0 && pending_answers.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
